// ===== design/trimmed_mean_sample_filter_defines.svh =====
// -----------------------------------------------------------------------------
// Trimmed mean sample filter assertion macros
// Shared concurrent assertion helpers, removed from synthesis builds.
// -----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define TMSF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmsf assertion failed");
`define TMSF_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tmsf forbidden condition seen");
`else
`define TMSF_ASSERT(lbl, clk, rst_n, prop)
`define TMSF_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== design/tmsf_pkg.sv =====
// -----------------------------------------------------------------------------
// Trimmed mean sample filter package
// Payload types and fixed constants shared by the filter modules.
// -----------------------------------------------------------------------------
package tmsf_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int CFG_W       = 5;
    localparam int MIN_BATCH   = 4;
    localparam int BATCH_RESET = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sample_failed;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered_value;
        logic                error;
    } t_out;

endpackage

// ===== design/tmsf_front.sv =====
// -----------------------------------------------------------------------------
// Trimmed mean sample filter front end
// Accumulates sum, minimum and maximum of a batch and emits one job per batch.
// -----------------------------------------------------------------------------
module tmsf_front
    import tmsf_pkg::*;
#(
    parameter int MAX_BATCH = 16,
    parameter int SB        = 12,
    parameter int NW        = 5,
    parameter int SUMW      = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_accept,
    input  t_in              i_item,
    output logic             o_push,
    output logic [SUMW-1:0]  o_job_sum,
    output logic [NW-1:0]    o_job_div,
    output logic             o_job_err
);

    localparam int EW = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0] r_bs;
    logic [NW-1:0]    r_cnt;
    logic [SUMW-1:0]  r_sum;
    logic [SB-1:0]    r_min;
    logic [SB-1:0]    r_max;

    logic [EW-1:0]   bs_ext;
    logic [NW-1:0]   n_eff;
    logic [SB-1:0]   s;
    logic [SUMW-1:0] n_sum;
    logic [SB-1:0]   n_min;
    logic [SB-1:0]   n_max;
    logic [NW-1:0]   n_cnt;
    logic            complete;

    always_comb begin
        bs_ext = EW'(r_bs);
        if (bs_ext < EW'(MIN_BATCH)) begin
            n_eff = NW'(MIN_BATCH);
        end else if (bs_ext > EW'(MAX_BATCH)) begin
            n_eff = NW'(MAX_BATCH);
        end else begin
            n_eff = NW'(bs_ext);
        end
        s        = i_item.sample[SB-1:0];
        n_sum    = r_sum + SUMW'(s);
        n_min    = (s < r_min) ? s : r_min;
        n_max    = (s > r_max) ? s : r_max;
        n_cnt    = r_cnt + NW'(1);
        complete = (n_cnt >= n_eff);
    end

    assign o_push    = i_accept && (i_item.sample_failed || complete);
    assign o_job_err = i_item.sample_failed;
    assign o_job_sum = n_sum - SUMW'(n_min) - SUMW'(n_max);
    assign o_job_div = n_eff - NW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs  <= CFG_W'(BATCH_RESET);
            r_cnt <= '0;
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (i_cfg_wr_en) begin
            r_bs  <= i_cfg_wr_data;
            r_cnt <= '0;
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (i_accept) begin
            if (i_item.sample_failed || complete) begin
                r_cnt <= '0;
                r_sum <= '0;
                r_min <= '1;
                r_max <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_sum <= n_sum;
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

endmodule

// ===== design/tmsf_queue.sv =====
// -----------------------------------------------------------------------------
// Trimmed mean sample filter job queue
// Small register FIFO that decouples the front end from the divider.
// -----------------------------------------------------------------------------
module tmsf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== design/tmsf_back.sv =====
// -----------------------------------------------------------------------------
// Trimmed mean sample filter back end
// Restoring divider, one quotient bit per cycle, with a registered result.
// -----------------------------------------------------------------------------
module tmsf_back
    import tmsf_pkg::*;
#(
    parameter int NW   = 5,
    parameter int SUMW = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  logic [SUMW-1:0] i_job_sum,
    input  logic [NW-1:0]   i_job_div,
    input  logic            i_job_err,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output t_out            o_data
);

    localparam int CW = $clog2(SUMW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [SUMW-1:0] r_quo;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_div;
    logic [CW-1:0]   r_cnt;
    logic            r_valid;
    t_out            r_data;

    logic [NW:0]              trial;
    logic                     ge;
    logic [NW-1:0]            n_rem;
    logic [SUMW-1:0]          n_quo;
    logic [SUMW+SAMPLE_W-1:0] quo_ext;

    always_comb begin
        trial   = {r_rem, r_quo[SUMW-1]};
        ge      = (trial >= {1'b0, r_div});
        n_rem   = ge ? NW'(trial - {1'b0, r_div}) : NW'(trial);
        n_quo   = {r_quo[SUMW-2:0], ge};
        quo_ext = {{SAMPLE_W{1'b0}}, n_quo};
    end

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_job_err) begin
                            r_data.filtered_value <= '0;
                            r_data.error          <= 1'b1;
                            r_valid               <= 1'b1;
                            r_state               <= S_OUT;
                        end else begin
                            r_quo   <= i_job_sum;
                            r_rem   <= '0;
                            r_div   <= i_job_div;
                            r_cnt   <= CW'(SUMW - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_data.filtered_value <= quo_ext[SAMPLE_W-1:0];
                        r_data.error          <= 1'b0;
                        r_valid               <= 1'b1;
                        r_state               <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/trimmed_mean_sample_filter.sv =====
// -----------------------------------------------------------------------------
// Trimmed mean sample filter
// Averages a batch of samples after dropping one minimum and one maximum.
//
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in_data (t_in)
// out      output     o_out_valid / i_out_ready  o_out_data (t_out)
// cfg      input      i_cfg_wr_en                i_cfg_wr_data (batch size)
//
// The front end takes one sample per cycle while the two-entry job queue has room.
// A full batch or a failed conversion queues one job; the divider works on one job
// at a time and pops the next one only after the output transaction completes.
// Error jobs skip the divider and go straight into the output register.
// Reset is synchronous and active low; a stalled output holds the divider, and
// the queue lets the front end keep collecting the next batch meanwhile.
// -----------------------------------------------------------------------------
`include "trimmed_mean_sample_filter_defines.svh"

module trimmed_mean_sample_filter
    import tmsf_pkg::*;
#(
    parameter int MAX_BATCH   = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data
);

    localparam int SB   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int NW   = $clog2(MAX_BATCH + 1);
    localparam int SUMW = SB + NW;
    localparam int JW   = SUMW + NW + 1;

    logic            accept;
    logic            push;
    logic [SUMW-1:0] f_sum;
    logic [NW-1:0]   f_div;
    logic            f_err;
    logic [JW-1:0]   q_data;
    logic            q_empty;
    logic            q_full;
    logic            pop;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    tmsf_front #(
        .MAX_BATCH (MAX_BATCH),
        .SB        (SB),
        .NW        (NW),
        .SUMW      (SUMW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_item        (i_in_data),
        .o_push        (push),
        .o_job_sum     (f_sum),
        .o_job_div     (f_div),
        .o_job_err     (f_err)
    );

    tmsf_queue #(
        .WIDTH (JW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_err, f_div, f_sum}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tmsf_back #(
        .NW   (NW),
        .SUMW (SUMW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_job_sum (q_data[SUMW-1:0]),
        .i_job_div (q_data[SUMW+NW-1:SUMW]),
        .i_job_err (q_data[JW-1]),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

    `TMSF_ASSERT(a_err_zero, i_clk, i_rst_n, (o_out_valid && o_out_data.error) |-> (o_out_data.filtered_value == '0))
    `TMSF_ASSERT(a_one_shot, i_clk, i_rst_n, (o_out_valid && i_out_ready) |=> !o_out_valid)
    `TMSF_NEVER(a_no_overflow, i_clk, i_rst_n, push && q_full && !pop)

endmodule
